@@ src/wps_pkg.sv @@
package wps_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [4:0]  FMT_LAST_IDX  = 5'd15;
  localparam logic [31:0] FMT_BYTES     = 32'd16;
  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [15:0] FMT_CHANNELS  = 16'd2;
  localparam logic [15:0] FMT_BITS      = 16'd16;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    KIND_FRAME    = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BAD_RIFF = 3'd2,
    KIND_BAD_WAVE = 3'd3,
    KIND_BAD_FMT  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_TAG   = 4'd3,
    PH_SIZE  = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_DATA  = 4'd7,
    PH_IDLE  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DIV_END
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_finish;
  } cmd_t;

  typedef struct packed {
    logic div_req;
    logic quot_zero;
    logic out_free;
  } status_t;

  function automatic out_item_t make_result(input kind_t kind, input logic [31:0] frame,
                                            input logic [31:0] rate, input logic last);
    out_item_t r;
    r.kind         = kind;
    r.left_sample  = (kind == KIND_FRAME) ? frame[15:0] : 16'sd0;
    r.right_sample = (kind == KIND_FRAME) ? frame[31:16] : 16'sd0;
    r.rate_hz      = rate;
    r.last         = last;
    return r;
  endfunction

endpackage

@@ src/wav_pcm_stereo_stream_parser_core.sv @@
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output side keeps up; a byte that gives two
// items (last frame, or a frame cut by end of file) holds input until the second item
// leaves the pending stage. The last byte of the data chunk size starts a bit-serial
// frame-count divide that holds input, at most once per file. Reset (rst_n low,
// synchronous) clears all parse state and drops any items still held in the output stages.
module wav_pcm_stereo_stream_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wps_pkg::out_item_t out_data
);

  wps_pkg::cmd_t    cmd;
  wps_pkg::status_t status;

  wps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wps_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ src/wps_ctrl.sv @@
module wps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wps_pkg::status_t status,
  output wps_pkg::cmd_t    cmd
);

  wps_pkg::ctrl_state_t              state_r, state_nxt;
  logic [wps_pkg::DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= wps_pkg::ST_RUN;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    div_cnt_nxt    = div_cnt_r;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.div_finish = 1'b0;
    unique case (state_r)
      wps_pkg::ST_RUN: begin
        in_ready   = status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept && status.div_req) begin
          div_cnt_nxt = '0;
          state_nxt   = wps_pkg::ST_DIV;
        end
      end
      wps_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == wps_pkg::DIV_CNT_W'(wps_pkg::DIV_STEPS - 1)) begin
          state_nxt = wps_pkg::ST_DIV_END;
        end
      end
      wps_pkg::ST_DIV_END: begin
        // a zero frame count pushes a done item, so wait for a free slot
        if (!status.quot_zero || status.out_free) begin
          cmd.div_finish = 1'b1;
          state_nxt      = wps_pkg::ST_RUN;
        end
      end
      default: state_nxt = wps_pkg::ST_RUN;
    endcase
  end

endmodule

@@ src/wps_datapath.sv @@
module wps_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  wps_pkg::in_item_t  in_data,
  input  wps_pkg::cmd_t      cmd,
  output wps_pkg::status_t   status,
  input  logic               out_ready,
  output logic               out_valid,
  output wps_pkg::out_item_t out_data
);

  // parse state
  wps_pkg::phase_t phase_r, phase_stp, phase_nxt;
  logic [31:0] field_shift_r, fs_stp, fs_nxt;
  logic [4:0]  byte_idx_r, bi_stp, bi_nxt;
  logic [31:0] chunk_tag_r, tag_stp, tag_nxt;
  logic [31:0] bytes_rem_r, rem_stp, rem_nxt;
  logic [15:0] format_code_r, fcode_stp, fcode_nxt;
  logic [15:0] channels_r, chan_stp, chan_nxt;
  logic [31:0] rate_r, rate_stp, rate_nxt;
  logic [15:0] block_align_r, align_stp, align_nxt;
  logic [15:0] bits_r, bits_stp, bits_nxt;
  logic [31:0] frames_r, frames_stp, frames_nxt;

  // divider
  logic [31:0] div_q_r;
  logic [15:0] div_rem_r;
  logic [16:0] div_trial;
  logic        div_ge;

  // output slot plus one pending item
  logic               out_valid_r, pend_valid_r;
  wps_pkg::out_item_t out_data_r, pend_r;

  logic [7:0]         b;
  logic               eof;
  logic [31:0]        fs_base, fs_new;
  logic               quad;
  logic               fmt_bad;
  logic               div_raw;
  logic [31:0]        skip_dec;
  logic [31:0]        fmt_rem;
  logic [31:0]        frames_dec;
  logic [31:0]        rate_put;
  wps_pkg::kind_t     eof_kind;
  logic               r0_v, r1_v;
  wps_pkg::out_item_t r0, r1, eof_item;

  always_comb begin
    b       = in_data.data_byte;
    eof     = in_data.end_of_file;
    fs_base = (byte_idx_r == 5'd0) ? 32'd0 : field_shift_r;
    fs_new  = fs_base | ({24'd0, b} << {byte_idx_r[1:0], 3'b000});
    quad    = byte_idx_r >= 5'd3;
    fmt_bad = (block_align_r == 16'd0) || (format_code_r != wps_pkg::FMT_PCM) ||
              (channels_r != wps_pkg::FMT_CHANNELS) || (bits_r != wps_pkg::FMT_BITS);
    skip_dec   = (bytes_rem_r != 32'd0) ? bytes_rem_r - 32'd1 : 32'd0;
    fmt_rem    = (bytes_rem_r > wps_pkg::FMT_BYTES) ? bytes_rem_r - wps_pkg::FMT_BYTES : 32'd0;
    frames_dec = (frames_r != 32'd0) ? frames_r - 32'd1 : 32'd0;
    rate_put   = (byte_idx_r[1:0] == 2'd0) ? {24'd0, b}
                 : rate_r | ({24'd0, b} << {byte_idx_r[1:0], 3'b000});

    phase_stp  = phase_r;
    fs_stp     = field_shift_r;
    bi_stp     = byte_idx_r;
    tag_stp    = chunk_tag_r;
    rem_stp    = bytes_rem_r;
    fcode_stp  = format_code_r;
    chan_stp   = channels_r;
    rate_stp   = rate_r;
    align_stp  = block_align_r;
    bits_stp   = bits_r;
    frames_stp = frames_r;
    div_raw    = 1'b0;
    r0_v       = 1'b0;
    r1_v       = 1'b0;
    r0         = '0;
    r1         = '0;

    if (phase_r < wps_pkg::PH_FMT || phase_r == wps_pkg::PH_DATA) begin
      fs_stp = fs_new;
    end

    unique case (phase_r)
      wps_pkg::PH_RIFF, wps_pkg::PH_RSIZE, wps_pkg::PH_WAVE, wps_pkg::PH_TAG: begin
        if (!quad) begin
          bi_stp = byte_idx_r + 5'd1;
        end else begin
          bi_stp = 5'd0;
          fs_stp = 32'd0;
          priority case (phase_r)
            wps_pkg::PH_RIFF: begin
              if (fs_new != wps_pkg::TAG_RIFF) begin
                r0_v      = 1'b1;
                r0        = wps_pkg::make_result(wps_pkg::KIND_BAD_RIFF, 32'd0, rate_r, 1'b1);
                phase_stp = wps_pkg::PH_IDLE;
              end else begin
                phase_stp = wps_pkg::PH_RSIZE;
              end
            end
            wps_pkg::PH_RSIZE: phase_stp = wps_pkg::PH_WAVE;
            wps_pkg::PH_WAVE: begin
              if (fs_new != wps_pkg::TAG_WAVE) begin
                r0_v      = 1'b1;
                r0        = wps_pkg::make_result(wps_pkg::KIND_BAD_WAVE, 32'd0, rate_r, 1'b1);
                phase_stp = wps_pkg::PH_IDLE;
              end else begin
                phase_stp = wps_pkg::PH_TAG;
              end
            end
            default: begin
              tag_stp   = fs_new;
              phase_stp = wps_pkg::PH_SIZE;
            end
          endcase
        end
      end
      wps_pkg::PH_SIZE: begin
        rem_stp = fs_new;
        if (!quad) begin
          bi_stp = byte_idx_r + 5'd1;
        end else begin
          bi_stp = 5'd0;
          fs_stp = 32'd0;
          if (chunk_tag_r == wps_pkg::TAG_FMT) begin
            phase_stp = wps_pkg::PH_FMT;
          end else if (chunk_tag_r == wps_pkg::TAG_DATA) begin
            if (fmt_bad) begin
              r0_v      = 1'b1;
              r0        = wps_pkg::make_result(wps_pkg::KIND_BAD_FMT, 32'd0, rate_r, 1'b1);
              phase_stp = wps_pkg::PH_IDLE;
            end else begin
              // frame count comes from the divider; a zero count ends the file there
              div_raw   = 1'b1;
              phase_stp = wps_pkg::PH_DATA;
            end
          end else begin
            phase_stp = (fs_new == 32'd0) ? wps_pkg::PH_TAG : wps_pkg::PH_SKIP;
          end
        end
      end
      wps_pkg::PH_FMT: begin
        priority if (byte_idx_r < 5'd2) begin
          fcode_stp = byte_idx_r[0] ? (format_code_r | {b, 8'd0}) : {8'd0, b};
        end else if (byte_idx_r < 5'd4) begin
          chan_stp = byte_idx_r[0] ? (channels_r | {b, 8'd0}) : {8'd0, b};
        end else if (byte_idx_r < 5'd8) begin
          rate_stp = rate_put;
        end else if (byte_idx_r < 5'd12) begin
          // byte rate: drop
        end else if (byte_idx_r < 5'd14) begin
          align_stp = byte_idx_r[0] ? (block_align_r | {b, 8'd0}) : {8'd0, b};
        end else begin
          bits_stp = byte_idx_r[0] ? (bits_r | {b, 8'd0}) : {8'd0, b};
        end
        if (byte_idx_r != wps_pkg::FMT_LAST_IDX) begin
          bi_stp = byte_idx_r + 5'd1;
        end else begin
          bi_stp    = 5'd0;
          fs_stp    = 32'd0;
          rem_stp   = fmt_rem;
          phase_stp = (fmt_rem == 32'd0) ? wps_pkg::PH_TAG : wps_pkg::PH_SKIP;
        end
      end
      wps_pkg::PH_SKIP: begin
        rem_stp = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_stp = wps_pkg::PH_TAG;
          bi_stp    = 5'd0;
          fs_stp    = 32'd0;
        end
      end
      wps_pkg::PH_DATA: begin
        if (!quad) begin
          bi_stp = byte_idx_r + 5'd1;
        end else begin
          bi_stp     = 5'd0;
          fs_stp     = 32'd0;
          frames_stp = frames_dec;
          r0_v       = 1'b1;
          r0         = wps_pkg::make_result(wps_pkg::KIND_FRAME, fs_new, rate_r, 1'b0);
          if (frames_dec == 32'd0) begin
            r1_v      = 1'b1;
            r1        = wps_pkg::make_result(wps_pkg::KIND_DONE, 32'd0, rate_r, 1'b1);
            phase_stp = wps_pkg::PH_IDLE;
          end
        end
      end
      wps_pkg::PH_IDLE: begin
        // hold until end of file
      end
      default: begin
      end
    endcase

    priority if (phase_stp == wps_pkg::PH_RIFF) begin
      eof_kind = wps_pkg::KIND_BAD_RIFF;
    end else if (phase_stp == wps_pkg::PH_RSIZE || phase_stp == wps_pkg::PH_WAVE) begin
      eof_kind = wps_pkg::KIND_BAD_WAVE;
    end else if (phase_stp == wps_pkg::PH_SIZE && tag_stp == wps_pkg::TAG_DATA && fmt_bad) begin
      eof_kind = wps_pkg::KIND_BAD_FMT;
    end else begin
      eof_kind = wps_pkg::KIND_DONE;
    end
    eof_item = wps_pkg::make_result(eof_kind, 32'd0, rate_stp, 1'b1);

    if (eof && phase_stp != wps_pkg::PH_IDLE) begin
      if (r0_v) begin
        r1_v = 1'b1;
        r1   = eof_item;
      end else begin
        r0_v = 1'b1;
        r0   = eof_item;
      end
    end

    if (eof) begin
      phase_nxt  = wps_pkg::PH_RIFF;
      fs_nxt     = 32'd0;
      bi_nxt     = 5'd0;
      tag_nxt    = 32'd0;
      rem_nxt    = 32'd0;
      fcode_nxt  = 16'd0;
      chan_nxt   = 16'd0;
      rate_nxt   = 32'd0;
      align_nxt  = 16'd0;
      bits_nxt   = 16'd0;
      frames_nxt = 32'd0;
    end else begin
      phase_nxt  = phase_stp;
      fs_nxt     = fs_stp;
      bi_nxt     = bi_stp;
      tag_nxt    = tag_stp;
      rem_nxt    = rem_stp;
      fcode_nxt  = fcode_stp;
      chan_nxt   = chan_stp;
      rate_nxt   = rate_stp;
      align_nxt  = align_stp;
      bits_nxt   = bits_stp;
      frames_nxt = frames_stp;
    end
  end

  assign div_trial = {div_rem_r, div_q_r[31]};
  assign div_ge    = div_trial >= {1'b0, block_align_r};

  assign status.div_req   = div_raw && !eof;
  assign status.quot_zero = div_q_r == 32'd0;
  assign status.out_free  = !pend_valid_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= wps_pkg::PH_RIFF;
      field_shift_r <= 32'd0;
      byte_idx_r    <= 5'd0;
      chunk_tag_r   <= 32'd0;
      bytes_rem_r   <= 32'd0;
      format_code_r <= 16'd0;
      channels_r    <= 16'd0;
      rate_r        <= 32'd0;
      block_align_r <= 16'd0;
      bits_r        <= 16'd0;
      frames_r      <= 32'd0;
    end else if (cmd.accept) begin
      phase_r       <= phase_nxt;
      field_shift_r <= fs_nxt;
      byte_idx_r    <= bi_nxt;
      chunk_tag_r   <= tag_nxt;
      bytes_rem_r   <= rem_nxt;
      format_code_r <= fcode_nxt;
      channels_r    <= chan_nxt;
      rate_r        <= rate_nxt;
      block_align_r <= align_nxt;
      bits_r        <= bits_nxt;
      frames_r      <= frames_nxt;
    end else if (cmd.div_finish) begin
      frames_r <= div_q_r;
      if (div_q_r == 32'd0) begin
        phase_r <= wps_pkg::PH_IDLE;
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept && status.div_req) begin
      div_q_r   <= fs_new;
      div_rem_r <= 16'd0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[30:0], div_ge};
      div_rem_r <= div_ge ? 16'(div_trial - {1'b0, block_align_r}) : div_trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (cmd.accept) begin
      out_valid_r  <= r0_v;
      pend_valid_r <= r1_v;
    end else if (cmd.div_finish && status.quot_zero) begin
      out_valid_r <= 1'b1;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data_r <= r0;
      pend_r     <= r1;
    end else if (cmd.div_finish && status.quot_zero) begin
      out_data_r <= wps_pkg::make_result(wps_pkg::KIND_DONE, 32'd0, rate_r, 1'b1);
    end else if (!out_valid_r || out_ready) begin
      out_data_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/wps_checker.sv @@
module wps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input wps_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != wps_pkg::KIND_FRAME |-> out_data.last)
    else $error("status item not marked last");

  a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == wps_pkg::KIND_FRAME |-> !out_data.last)
    else $error("frame item marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != wps_pkg::KIND_FRAME |->
      out_data.left_sample == 16'sd0 && out_data.right_sample == 16'sd0)
    else $error("status item carries sample data");

endmodule

bind wav_pcm_stereo_stream_parser_core wps_checker u_wps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/wav_pcm_stereo_stream_parser_core_tb.sv @@
`timescale 1ns / 100ps

module wav_pcm_stereo_stream_parser_core_tb;
  import wps_pkg::*;

  localparam int unsigned ITEMS        = 1950;
  localparam int unsigned TAIL_CALM    = 150;
  localparam int unsigned MOOD_SPAN    = 300;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned WHOLE        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic     hold;
    in_item_t item;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  wav_pcm_stereo_stream_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  stim_t       byte_plan[$];
  logic [7:0]  file_buf[$];
  out_item_t   pending_results[$];
  int unsigned planned = 0;
  int unsigned total_items = 0;
  int unsigned sent = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mood_cnt = 0;
  int unsigned idle_odds = 0;
  logic        calm = 1'b0;
  logic        settled = 1'b1;

  // Parser state mirror
  phase_t      wav_phase;
  logic [31:0] acc_word;
  logic [4:0]  acc_idx;
  logic [31:0] chunk_id;
  logic [31:0] chunk_left;
  logic [15:0] fmt_code;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_align;
  logic [15:0] fmt_bits;
  logic [31:0] frames_left;

  function automatic void goto_phase(input phase_t ph);
    wav_phase = ph;
    acc_idx   = '0;
    acc_word  = '0;
  endfunction

  function automatic void restart_parse();
    goto_phase(PH_RIFF);
    chunk_id    = '0;
    chunk_left  = '0;
    fmt_code    = '0;
    fmt_chans   = '0;
    fmt_rate    = '0;
    fmt_align   = '0;
    fmt_bits    = '0;
    frames_left = '0;
  endfunction

  function automatic logic fmt_unsupported();
    return fmt_align == 16'd0 || fmt_code != FMT_PCM || fmt_chans != FMT_CHANNELS ||
           fmt_bits != FMT_BITS;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [31:0] frame,
                                       input logic fin);
    out_item_t r;
    r.kind         = k;
    r.left_sample  = (k == KIND_FRAME) ? frame[15:0] : 16'd0;
    r.right_sample = (k == KIND_FRAME) ? frame[31:16] : 16'd0;
    r.rate_hz      = fmt_rate;
    r.last         = fin;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void parse_wav_byte(input in_item_t it);
    logic [7:0] b;
    logic [4:0] k;
    logic       quad;
    b = it.data_byte;
    if (wav_phase < PH_FMT || wav_phase == PH_DATA) begin
      if (acc_idx == 5'd0) acc_word = '0;
      acc_word |= 32'(b) << (8 * acc_idx[1:0]);
    end
    quad = acc_idx >= 5'd3;
    case (wav_phase)
      PH_RIFF: begin
        if (!quad) acc_idx++;
        else if (acc_word != TAG_RIFF) begin
          queue_result(KIND_BAD_RIFF, '0, 1'b1);
          goto_phase(PH_IDLE);
        end else goto_phase(PH_RSIZE);
      end
      PH_RSIZE: begin
        if (!quad) acc_idx++;
        else goto_phase(PH_WAVE);
      end
      PH_WAVE: begin
        if (!quad) acc_idx++;
        else if (acc_word != TAG_WAVE) begin
          queue_result(KIND_BAD_WAVE, '0, 1'b1);
          goto_phase(PH_IDLE);
        end else goto_phase(PH_TAG);
      end
      PH_TAG: begin
        if (!quad) acc_idx++;
        else begin
          chunk_id = acc_word;
          goto_phase(PH_SIZE);
        end
      end
      PH_SIZE: begin
        chunk_left = acc_word;
        if (!quad) acc_idx++;
        else if (chunk_id == TAG_FMT) goto_phase(PH_FMT);
        else if (chunk_id == TAG_DATA) begin
          if (fmt_unsupported()) begin
            queue_result(KIND_BAD_FMT, '0, 1'b1);
            goto_phase(PH_IDLE);
          end else begin
            frames_left = chunk_left / 32'(fmt_align);
            if (frames_left == 32'd0) begin
              queue_result(KIND_DONE, '0, 1'b1);
              goto_phase(PH_IDLE);
            end else goto_phase(PH_DATA);
          end
        end else if (chunk_left == 32'd0) goto_phase(PH_TAG);
        else goto_phase(PH_SKIP);
      end
      PH_FMT: begin
        k = acc_idx;
        // fields fill low byte first; the first byte clears the upper bytes
        case (k)
          5'd0:  fmt_code = {8'h00, b};
          5'd1:  fmt_code[15:8] = b;
          5'd2:  fmt_chans = {8'h00, b};
          5'd3:  fmt_chans[15:8] = b;
          5'd4:  fmt_rate = {24'h0, b};
          5'd5:  fmt_rate[15:8] = b;
          5'd6:  fmt_rate[23:16] = b;
          5'd7:  fmt_rate[31:24] = b;
          5'd12: fmt_align = {8'h00, b};
          5'd13: fmt_align[15:8] = b;
          5'd14: fmt_bits = {8'h00, b};
          5'd15: fmt_bits[15:8] = b;
          default: ;
        endcase
        if (k < FMT_LAST_IDX) acc_idx = k + 5'd1;
        else begin
          chunk_left = (chunk_left > FMT_BYTES) ? chunk_left - FMT_BYTES : 32'd0;
          if (chunk_left == 32'd0) goto_phase(PH_TAG);
          else goto_phase(PH_SKIP);
        end
      end
      PH_SKIP: begin
        if (chunk_left != 32'd0) chunk_left--;
        if (chunk_left == 32'd0) goto_phase(PH_TAG);
      end
      PH_DATA: begin
        if (!quad) acc_idx++;
        else begin
          queue_result(KIND_FRAME, acc_word, 1'b0);
          if (frames_left != 32'd0) frames_left--;
          if (frames_left == 32'd0) begin
            queue_result(KIND_DONE, '0, 1'b1);
            goto_phase(PH_IDLE);
          end else goto_phase(PH_DATA);
        end
      end
      default: ;
    endcase
    if (it.end_of_file) begin
      if (wav_phase != PH_IDLE) begin
        if (wav_phase == PH_RIFF) queue_result(KIND_BAD_RIFF, '0, 1'b1);
        else if (wav_phase == PH_RSIZE || wav_phase == PH_WAVE)
          queue_result(KIND_BAD_WAVE, '0, 1'b1);
        else if (wav_phase == PH_SIZE && chunk_id == TAG_DATA && fmt_unsupported())
          queue_result(KIND_BAD_FMT, '0, 1'b1);
        else queue_result(KIND_DONE, '0, 1'b1);
      end
      restart_parse();
    end
  endfunction

  // File assembly
  task automatic add_byte(input logic [7:0] v);
    file_buf.insert(file_buf.size(), v);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  task automatic put_half(input logic [15:0] h);
    add_byte(h[7:0]);
    add_byte(h[15:8]);
  endtask

  task automatic put_junk(input int unsigned count);
    int unsigned n;
    repeat (count) begin
      n = $urandom_range(0, 6);
      put_word($urandom());
      put_word(n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_wav(input logic [15:0] code, input logic [15:0] chans,
                           input logic [15:0] align, input logic [15:0] bits,
                           input logic [31:0] rate, input int unsigned fmt_len,
                           input int unsigned frames, input logic [31:0] pad,
                           input int unsigned extras);
    file_buf.delete();
    put_word(TAG_RIFF);
    put_word($urandom());
    put_word(TAG_WAVE);
    put_junk(extras);
    put_word(TAG_FMT);
    put_word(fmt_len);
    put_half(code);
    put_half(chans);
    put_word(rate);
    put_word($urandom());
    put_half(align);
    put_half(bits);
    repeat ((fmt_len > 16) ? fmt_len - 16 : 0) add_byte(8'($urandom_range(0, 255)));
    put_junk((extras != 0) ? $urandom_range(0, 1) : 0);
    put_word(TAG_DATA);
    put_word(frames * align + pad);
    repeat (frames * 4) add_byte(8'($urandom_range(0, 255)));
  endtask

  // cut indexes the last file byte, which has end of file unless ignored tail junk follows
  task automatic queue_file(input int unsigned cut, input int unsigned tail, input logic hold);
    int unsigned len;
    stim_t s;
    len = (cut < file_buf.size()) ? cut + 1 : file_buf.size();
    for (int i = 0; i < len; i++) begin
      s.hold             = hold && (i == 0);
      s.item.data_byte   = file_buf[i];
      s.item.end_of_file = 1'b0;
      byte_plan.insert(byte_plan.size(), s);
    end
    planned += len;
    repeat (tail) begin
      s.hold             = 1'b0;
      s.item.data_byte   = 8'($urandom_range(0, 255));
      s.item.end_of_file = 1'b0;
      byte_plan.insert(byte_plan.size(), s);
    end
    s = byte_plan.pop_back();
    s.item.end_of_file = 1'b1;
    byte_plan.insert(byte_plan.size(), s);
  endtask

  always @(posedge clk) begin
    mood_cnt <= mood_cnt + 1;
    if (mood_cnt % MOOD_SPAN == 0) idle_odds <= $urandom_range(0, 3);
  end

  always @(posedge clk) begin : feeder
    stim_t next_byte;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      sent     <= 0;
    end else begin
      if (in_valid && in_ready) sent <= sent + 1;
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_plan.size() == 0) begin
          in_valid <= 1'b0;
        end else if (byte_plan[0].hold && (in_valid || !settled)) begin
          // hold off until every outstanding result has been checked
          in_valid <= 1'b0;
        end else if (!calm && idle_odds != 0 && $urandom_range(0, 9) < idle_odds * 2) begin
          gap_left <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          next_byte = byte_plan.pop_front();
          in_data  <= next_byte.item;
          in_valid <= 1'b1;
        end
      end
    end
    calm <= byte_plan.size() < TAIL_CALM;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && idle_odds != 0 && $urandom_range(0, 9) < idle_odds * 2) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      settled <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected item: expected none, got kind=%0d l=%0d r=%0d rate=%h last=%b",
                   $time, out_data.kind, out_data.left_sample, out_data.right_sample,
                   out_data.rate_hz, out_data.last);
        end else begin
          want = pending_results.pop_front();
          if (out_data.kind !== want.kind || out_data.left_sample !== want.left_sample ||
              out_data.right_sample !== want.right_sample ||
              out_data.rate_hz !== want.rate_hz || out_data.last !== want.last) begin
            errors++;
            $display("%0t mismatch: expected kind=%0d l=%0d r=%0d rate=%h last=%b", $time,
                     want.kind, want.left_sample, want.right_sample, want.rate_hz,
                     want.last);
            $display("%0t          got      kind=%0d l=%0d r=%0d rate=%h last=%b", $time,
                     out_data.kind, out_data.left_sample, out_data.right_sample,
                     out_data.rate_hz, out_data.last);
          end
        end
      end
      if (in_valid && in_ready) parse_wav_byte(in_data);
      settled <= (pending_results.size() == 0);
    end
  end

  initial begin
    #400_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned style, cut, tail, frames, fmt_len, file_no;
    logic [15:0] code, chans, bits, align;
    logic [31:0] rate, pad;
    restart_parse();

    // end of file on the very first byte
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 1, 0, 0);
    queue_file(0, 0, 1'b0);
    // bad RIFF tag, then ignored bytes up to end of file
    file_buf[3] = 8'h58;
    queue_file(5, 0, 1'b0);
    // end of file inside the RIFF size
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 1, 0, 0);
    queue_file(6, 0, 1'b0);
    // bad WAVE tag with end of file on the same byte
    file_buf[11] = 8'h00;
    queue_file(11, 0, 1'b0);
    // minimal good file, entered only after everything before it has drained
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, 32'hFFFF_FFFF, 16, 1, 0, 0);
    queue_file(WHOLE, 0, 1'b1);
    // short fmt chunk, zero rate, trailing junk
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, 32'd0, 4, 2, 3, 1);
    queue_file(WHOLE, 2, 1'b0);
    // surplus fmt bytes and a wide block align
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd8, FMT_BITS, $urandom(), 22, 3, 5, 2);
    queue_file(WHOLE, 0, 1'b0);
    // zero frames
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 0, 3, 0);
    queue_file(WHOLE, 3, 1'b0);
    // end of file inside the data size, bad then good format
    build_wav(FMT_PCM, 16'd1, 16'd4, FMT_BITS, $urandom(), 16, 2, 0, 0);
    queue_file(41, 0, 1'b0);
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 2, 0, 0);
    queue_file(42, 0, 1'b0);
    // unsupported bits, then zero block align
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, 16'd8, $urandom(), 16, 2, 0, 0);
    queue_file(WHOLE, 0, 1'b0);
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd0, FMT_BITS, $urandom(), 16, 2, 0, 0);
    queue_file(WHOLE, 0, 1'b0);
    // end of file mid frame, and on the last byte of a frame that is not the final one
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 3, 0, 0);
    queue_file(49, 0, 1'b0);
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 3, 0, 0);
    queue_file(47, 0, 1'b0);
    // huge data size cut short by end of file
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 2, 32'hFFFF_FFF0, 0);
    queue_file(WHOLE, 0, 1'b0);
    // end of file inside fmt, and inside an unknown chunk
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 2, 0, 0);
    queue_file(25, 0, 1'b0);
    build_wav(FMT_PCM, FMT_CHANNELS, 16'd4, FMT_BITS, $urandom(), 16, 2, 0, 1);
    queue_file(14, 0, 1'b0);

    file_no = 0;
    while (planned < ITEMS) begin
      style   = $urandom_range(0, 99);
      align   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 12)) : 16'd4;
      frames  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      fmt_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : 16;
      case ($urandom_range(0, 3))
        0:       rate = 32'd0;
        1:       rate = 32'hFFFF_FFFF;
        default: rate = $urandom();
      endcase
      code  = FMT_PCM;
      chans = FMT_CHANNELS;
      bits  = FMT_BITS;
      if (style < 12) begin
        case ($urandom_range(0, 3))
          0:       code = 16'($urandom());
          1:       chans = 16'($urandom_range(0, 8));
          2:       bits = 16'($urandom());
          default: align = 16'd0;
        endcase
      end
      pad = (align == 16'd0) ? 32'd0 : $urandom_range(0, 32'(align) - 1);
      build_wav(code, chans, align, bits, rate, fmt_len, frames, pad, $urandom_range(0, 2));
      cut  = WHOLE;
      tail = 0;
      if (style >= 12 && style < 20)
        file_buf[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
      if (style >= 20 && style < 40) cut = $urandom_range(0, file_buf.size() - 1);
      if (style >= 40 && style < 50) tail = $urandom_range(1, 4);
      if (style >= 96) begin
        file_buf.delete();
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
      end
      queue_file(cut, tail, file_no == 8);
      file_no++;
    end
    total_items = byte_plan.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (sent != total_items || !settled);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t expected %0d more items, got none", $time, pending_results.size());
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ wav_pcm_stereo_stream_parser_core.f @@
src/wps_pkg.sv
src/wps_ctrl.sv
src/wps_datapath.sv
src/wav_pcm_stereo_stream_parser_core.sv
src/wps_checker.sv
tb/wav_pcm_stereo_stream_parser_core_tb.sv
